// ----- hw/rtl/lcdns_pkg.sv -----
// Package for the character LCD nibble sequencer: operation codes, command
// kinds, queue entry and configuration types, reset values and fixed bytes.
// No dependencies; every other file of the block but lcdns_if refers to it by scoped name.
package lcdns_pkg;

  // Operation codes of an input item; code 3 means nothing and is ignored.
  typedef enum logic [1:0] {
    OpInit  = 2'd0,
    OpClear = 2'd1,
    OpWrite = 2'd2
  } op_e;

  // Work carried from the front to the back through the queue.
  typedef enum logic [1:0] {
    KindInit  = 2'd0,
    KindClear = 2'd1,
    KindWrite = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] char_code;
  } qentry_t;

  // Command bytes sent during initialisation.
  typedef struct packed {
    logic [7:0] function_set_cmd;
    logic [7:0] shift_cmd;
    logic [7:0] display_cmd;
    logic [7:0] entry_mode_cmd;
  } cfg_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgFunctionSet = 2'd0;
  localparam logic [1:0] CfgShift       = 2'd1;
  localparam logic [1:0] CfgDisplay     = 2'd2;
  localparam logic [1:0] CfgEntryMode   = 2'd3;

  localparam logic [7:0] FunctionSetReset = 8'h20;
  localparam logic [7:0] ShiftReset       = 8'h14;
  localparam logic [7:0] DisplayReset     = 8'h0C;
  localparam logic [7:0] EntryModeReset   = 8'h06;

  // Fixed bytes and nibbles of the bus sequences.
  localparam logic [7:0] ClearDisplayCmd = 8'h01;
  localparam logic [7:0] ReturnHomeCmd   = 8'h02;
  localparam logic [3:0] InitNibble      = 4'h2;

  // Step numbers within the initialisation sequence.
  localparam logic [3:0] StepClearFirst = 4'd9;
  localparam logic [3:0] StepInitLast   = 4'd12;

  // Delay codes, in units of 10 ms.
  localparam logic [1:0] WaitShort = 2'd1;
  localparam logic [1:0] WaitLong  = 2'd3;

  localparam int unsigned ColumnWidth = 5;
  localparam int unsigned LineLengthDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;

endpackage

// ----- hw/rtl/lcdns_if.sv -----
// Valid/ready channel interfaces for the LCD nibble sequencer: the operation
// channel and the nibble channel. Depends on nothing but plain logic types.

interface lcdns_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;

  modport source (output valid, operation, char_code, input ready);
  modport sink (input valid, operation, char_code, output ready);
endinterface

interface lcdns_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble_out;
  logic       wait_before;
  logic [1:0] wait_after;
  logic       last;

  modport source (output valid, reg_select, nibble_out, wait_before, wait_after, last,
                  input ready);
  modport sink (input valid, reg_select, nibble_out, wait_before, wait_after, last,
                output ready);
endinterface

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer: configuration registers,
// front, queue and back. Depends on lcdns_pkg, lcdns_if, lcdns_front,
// lcdns_queue and lcdns_back.
//
// Usage: operations (init, clear, write character) enter on in_ch and the
// resulting 4-bit bus transfers leave on out_ch, one nibble per transaction,
// with register select, delays in 10 ms units and a flag on the final nibble
// of each operation. Init yields 13 nibbles, clear 4, a character write 2;
// a dropped write or a NUL yields none.
// The front accepts one operation per cycle while the queue has room
// (QUEUE_DEPTH entries). The back's single nibble generator emits one nibble
// per cycle while queued work waits and the receiver takes each nibble.
// The first nibble of an operation passes through the queue and then the
// output register before it is valid.
// When the receiver stalls, the output register holds its nibble, the back
// stops stepping and the queue fills; in_ch.ready falls once it is full.
// Reset clears the queue, the line column and the end-of-line flag and loads
// the default command bytes; no clearing pass is needed.
// Configuration writes are taken at any cycle but should only be made while
// the block is idle.
module char_lcd_nibble_sequencer #(
  parameter int unsigned LINE_LENGTH = lcdns_pkg::LineLengthDefault,
  parameter int unsigned QUEUE_DEPTH = lcdns_pkg::QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcdns_in_if.sink     in_ch,
  lcdns_out_if.source  out_ch,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  lcdns_pkg::cfg_t    cfg_q;
  lcdns_pkg::qentry_t push_entry, head_entry;
  logic push, queue_full, head_valid, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set_cmd <= lcdns_pkg::FunctionSetReset;
      cfg_q.shift_cmd        <= lcdns_pkg::ShiftReset;
      cfg_q.display_cmd      <= lcdns_pkg::DisplayReset;
      cfg_q.entry_mode_cmd   <= lcdns_pkg::EntryModeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcdns_pkg::CfgFunctionSet: cfg_q.function_set_cmd <= cfg_data_i;
        lcdns_pkg::CfgShift:       cfg_q.shift_cmd        <= cfg_data_i;
        lcdns_pkg::CfgDisplay:     cfg_q.display_cmd      <= cfg_data_i;
        default:                   cfg_q.entry_mode_cmd   <= cfg_data_i;
      endcase
    end
  end

  lcdns_front #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .operation_i  (in_ch.operation),
    .char_code_i  (in_ch.char_code),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  lcdns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_entry_i  (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .reg_select_o  (out_ch.reg_select),
    .nibble_out_o  (out_ch.nibble_out),
    .wait_before_o (out_ch.wait_before),
    .wait_after_o  (out_ch.wait_after),
    .last_o        (out_ch.last)
  );

`ifndef ASSERT_OFF
  // Only the opening nibble of init waits beforehand, and it is command 0x2.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.wait_before |->
      !out_ch.reg_select && (out_ch.nibble_out == lcdns_pkg::InitNibble) && !out_ch.last)
    else $error("wait_before on a nibble other than the init opener");

  // Data nibbles always carry a short wait after them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.reg_select |->
      !out_ch.wait_before && (out_ch.wait_after == lcdns_pkg::WaitShort))
    else $error("data nibble with wrong delays");

  // A long wait only follows the low nibble of a clear or home command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.wait_after == lcdns_pkg::WaitLong) |->
      !out_ch.reg_select && ((out_ch.nibble_out == lcdns_pkg::ClearDisplayCmd[3:0]) ||
                             (out_ch.nibble_out == lcdns_pkg::ReturnHomeCmd[3:0])))
    else $error("long wait on an unexpected nibble");

  // The queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_full |-> !push)
    else $error("push into a full queue");
`endif

endmodule

// ----- hw/rtl/lcdns_front.sv -----
// Front of the LCD nibble sequencer: accepts operations, tracks the line
// column and the end-of-line flag, and queues the work that yields nibbles.
// Depends on lcdns_pkg.
module lcdns_front #(
  parameter int unsigned LINE_LENGTH = lcdns_pkg::LineLengthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          char_code_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output lcdns_pkg::qentry_t  push_entry_o
);

  localparam logic [lcdns_pkg::ColumnWidth-1:0] LineLen =
    lcdns_pkg::ColumnWidth'(LINE_LENGTH);

  logic [lcdns_pkg::ColumnWidth-1:0] column_q, column_d;
  logic line_ended_q, line_ended_d;
  logic accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Classify the operation and update the line state at acceptance.
  always_comb begin
    column_d               = column_q;
    line_ended_d           = line_ended_q;
    push_o                 = 1'b0;
    push_entry_o.kind      = lcdns_pkg::KindWrite;
    push_entry_o.char_code = char_code_i;
    if (accept) begin
      case (operation_i)
        lcdns_pkg::OpInit: begin
          push_o            = 1'b1;
          push_entry_o.kind = lcdns_pkg::KindInit;
          column_d          = '0;
          line_ended_d      = 1'b0;
        end
        lcdns_pkg::OpClear: begin
          push_o            = 1'b1;
          push_entry_o.kind = lcdns_pkg::KindClear;
          column_d          = '0;
          line_ended_d      = 1'b0;
        end
        lcdns_pkg::OpWrite: begin
          if (!line_ended_q && (column_q < LineLen)) begin
            if (char_code_i == 8'h00) begin
              line_ended_d = 1'b1;
            end else begin
              push_o   = 1'b1;
              column_d = column_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      line_ended_q <= 1'b0;
    end else begin
      column_q     <= column_d;
      line_ended_q <= line_ended_d;
    end
  end

endmodule

// ----- hw/rtl/lcdns_queue.sv -----
// Short first-in first-out queue between the front and the back of the
// LCD nibble sequencer. Depends on lcdns_pkg for the entry type.
module lcdns_queue #(
  parameter int unsigned DEPTH = lcdns_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcdns_pkg::qentry_t push_entry_i,
  output logic               full_o,
  output logic               head_valid_o,
  output lcdns_pkg::qentry_t head_entry_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  lcdns_pkg::qentry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; the front only pushes when the queue is not full.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hw/rtl/lcdns_back.sv -----
// Back of the LCD nibble sequencer: steps through the nibbles of the queued
// work and holds each in an output register until it is taken.
// Depends on lcdns_pkg.
module lcdns_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcdns_pkg::cfg_t    cfg_i,
  input  logic               head_valid_i,
  input  lcdns_pkg::qentry_t head_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               reg_select_o,
  output logic [3:0]         nibble_out_o,
  output logic               wait_before_o,
  output logic [1:0]         wait_after_o,
  output logic               last_o
);

  logic [3:0] step_q;
  logic [3:0] seq_step;
  logic [2:0] cmd_off;
  logic [7:0] cfg_byte;
  logic       out_valid_q;
  logic       rs_q, wb_q, last_q;
  logic [3:0] nib_q;
  logic [1:0] wa_q;
  logic       advance;
  logic       rs_n, wb_n, last_n;
  logic [3:0] nib_n;
  logic [1:0] wa_n;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && last_n;

  // A clear runs the tail of the initialisation sequence.
  assign seq_step = (head_entry_i.kind == lcdns_pkg::KindClear) ?
                    (step_q + lcdns_pkg::StepClearFirst) : step_q;
  assign cmd_off  = 3'(seq_step - 4'd1);

  always_comb begin
    case (cmd_off[2:1])
      lcdns_pkg::CfgFunctionSet: cfg_byte = cfg_i.function_set_cmd;
      lcdns_pkg::CfgShift:       cfg_byte = cfg_i.shift_cmd;
      lcdns_pkg::CfgDisplay:     cfg_byte = cfg_i.display_cmd;
      default:                   cfg_byte = cfg_i.entry_mode_cmd;
    endcase
  end

  // Nibble generator for the current step.
  always_comb begin
    rs_n   = 1'b0;
    wb_n   = 1'b0;
    wa_n   = lcdns_pkg::WaitShort;
    nib_n  = lcdns_pkg::InitNibble;
    last_n = 1'b0;
    if (head_entry_i.kind == lcdns_pkg::KindWrite) begin
      rs_n   = 1'b1;
      last_n = step_q[0];
      nib_n  = step_q[0] ? head_entry_i.char_code[3:0] : head_entry_i.char_code[7:4];
    end else begin
      last_n = (seq_step == lcdns_pkg::StepInitLast);
      case (seq_step) inside
        4'd0: begin
          wb_n  = 1'b1;
          nib_n = lcdns_pkg::InitNibble;
        end
        [4'd1:4'd8]: begin
          nib_n = seq_step[0] ? cfg_byte[7:4] : cfg_byte[3:0];
        end
        4'd9: begin
          nib_n = lcdns_pkg::ClearDisplayCmd[7:4];
        end
        4'd10: begin
          nib_n = lcdns_pkg::ClearDisplayCmd[3:0];
          wa_n  = lcdns_pkg::WaitLong;
        end
        4'd11: begin
          nib_n = lcdns_pkg::ReturnHomeCmd[7:4];
        end
        default: begin
          nib_n = lcdns_pkg::ReturnHomeCmd[3:0];
          wa_n  = lcdns_pkg::WaitLong;
        end
      endcase
    end
  end

  // Step counter and output handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= last_n ? 4'd0 : step_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rs_q   <= rs_n;
      nib_q  <= nib_n;
      wb_q   <= wb_n;
      wa_q   <= wa_n;
      last_q <= last_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_select_o  = rs_q;
  assign nibble_out_o  = nib_q;
  assign wait_before_o = wb_q;
  assign wait_after_o  = wa_q;
  assign last_o        = last_q;

endmodule
